### hw/rtl/bapm_pkg.sv
// Shared types and constants of the block-average palette matcher.
// Used by every module under hw/rtl; depends on nothing else.
package bapm_pkg;

  localparam int PALETTE_DEPTH   = 1024;
  localparam int MAX_TILE_PIXELS = 65536;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int COLOR_W   = NUM_CH * CH_W;
  localparam int SUM_W     = 24;
  localparam int TALLY_W   = $clog2(MAX_TILE_PIXELS + 1);
  localparam int IDX_W     = $clog2(PALETTE_DEPTH);
  localparam int CNT_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int DIST_W    = 18;
  localparam int SIDE_W    = 7;
  localparam int OUT_IDX_W = 10;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 56;

  localparam logic [SIDE_W-1:0] REGION_SIDE_RESET = SIDE_W'(10);

  typedef enum logic [1:0] {
    OP_TILE   = 2'd0,
    OP_REGION = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_SEARCH,
    ST_RESULT
  } state_e;

  // Channel 0 is red, 1 green, 2 blue.
  typedef struct packed {
    logic                           start;
    logic [NUM_CH-1:0][SUM_W-1:0]   dividend;
    logic [TALLY_W-1:0]             divisor;
  } div_req_t;

  typedef struct packed {
    logic                           done;
    logic [NUM_CH-1:0][CH_W-1:0]    avg;
  } div_rsp_t;

endpackage

### hw/rtl/block_average_palette_match.sv
// Block-average palette matcher: pixel accumulator, averaging divider and palette walk.
// Depends on bapm_pkg, bapm_divider and bapm_palette_ram.
// Pixels that do not end a group are taken one per cycle while the block is idle. A tile end
// goes through the divider, then a palette write; a region end through the divider,
// then one palette read per cycle into a read, distance and compare pipeline. A waiting
// result does not stop pixel intake; the next group end then waits in the result step, taking no input.
// Reset empties the palette, clears the sums and sets region_side to 10.
module block_average_palette_match (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [23:0]                       s_axis_tdata,
  // op [1:0]
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status [1:0], entry_index [11:2], best_distance [29:12],
  // avg_red [37:30], avg_green [45:38], avg_blue [53:46], zeros above
  output logic [bapm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind [0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bapm_pkg::SIDE_W-1:0]       cfg_data_i
);
  import bapm_pkg::*;

  state_e                        state_q, state_d;
  logic [NUM_CH-1:0][SUM_W-1:0]  sum_q, sum_d, sum_acc;
  logic [TALLY_W-1:0]            tally_q, tally_d, tally_acc;
  logic [CNT_W-1:0]              count_q, count_d;
  logic                          region_q, region_d;
  logic [SIDE_W-1:0]             region_side_q;
  logic [NUM_CH-1:0][CH_W-1:0]   avg_q, avg_d;
  status_e                       res_status_q, res_status_d;
  logic [IDX_W-1:0]              res_idx_q, res_idx_d;
  logic [DIST_W-1:0]             res_dist_q, res_dist_d;
  logic [CNT_W-1:0]              addr_q, addr_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]              rd_idx_q, rd_idx_d;
  logic                          dist_vld_q, dist_vld_d;
  logic [IDX_W-1:0]              dist_idx_q, dist_idx_d;
  logic [DIST_W-1:0]             dist_q, dist_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;
  logic                          out_kind_q;
  status_e                       out_status_q;
  logic [IDX_W-1:0]              out_idx_q;
  logic [DIST_W-1:0]             out_dist_q;
  logic [NUM_CH-1:0][CH_W-1:0]   out_avg_q;

  logic [NUM_CH-1:0][CH_W-1:0]   pix;
  logic [SIDE_W-1:0]             side_eff;
  logic [2*SIDE_W-1:0]           side_sq;
  logic                          issue;
  logic                          ram_we;
  logic [COLOR_W-1:0]            ram_rdata;
  logic [CH_W-1:0]               adiff [NUM_CH];
  logic [2*CH_W-1:0]             sq    [NUM_CH];
  logic [DIST_W-1:0]             dist_nx;
  div_req_t                      div_req;
  div_rsp_t                      div_rsp;

  assign cfg_ready_o = 1'b1;
  assign pix         = s_axis_tdata;
  assign side_eff    = (region_side_q == '0) ? SIDE_W'(1) : region_side_q;
  assign side_sq     = side_eff * side_eff;

  // Accumulation stops once the tally reaches the pixel limit.
  always_comb begin
    sum_acc   = sum_q;
    tally_acc = tally_q;
    if (tally_q < TALLY_W'(MAX_TILE_PIXELS)) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_acc[c] = sum_q[c] + SUM_W'(pix[c]);
      end
      tally_acc = tally_q + 1'b1;
    end
  end

  // Palette colors are stored with red in the top byte.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [CH_W-1:0] pc;
      pc       = ram_rdata[COLOR_W-1-c*CH_W -: CH_W];
      adiff[c] = (pc > avg_q[c]) ? (pc - avg_q[c]) : (avg_q[c] - pc);
      sq[c]    = adiff[c] * adiff[c];
    end
    dist_nx = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  assign issue = (state_q == ST_SEARCH) && (addr_q < count_q);

  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    tally_d       = tally_q;
    count_d       = count_q;
    region_d      = region_q;
    avg_d         = avg_q;
    res_status_d  = res_status_q;
    res_idx_d     = res_idx_q;
    res_dist_d    = res_dist_q;
    addr_d        = addr_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    dist_vld_d    = 1'b0;
    dist_idx_d    = dist_idx_q;
    dist_d        = dist_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_acc;
    div_req.divisor  = (s_axis_tuser == OP_REGION) ? TALLY_W'(side_sq) : tally_acc;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (s_axis_tuser) inside
            OP_TILE, OP_REGION: begin
              sum_d   = sum_acc;
              tally_d = tally_acc;
              if (s_axis_tlast) begin
                div_req.start = 1'b1;
                region_d      = (s_axis_tuser == OP_REGION);
                sum_d         = '0;
                tally_d       = '0;
                state_d       = ST_DIVIDE;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              sum_d   = '0;
              tally_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          avg_d      = div_rsp.avg;
          res_idx_d  = '0;
          res_dist_d = '0;
          if (!region_q) begin
            state_d = ST_STORE;
          end else if (count_q == '0) begin
            res_status_d = STAT_EMPTY;
            state_d      = ST_RESULT;
          end else begin
            res_status_d = STAT_OK;
            addr_d       = '0;
            state_d      = ST_SEARCH;
          end
        end
      end
      ST_STORE: begin
        if (count_q >= CNT_W'(PALETTE_DEPTH)) begin
          res_status_d = STAT_FULL;
        end else begin
          ram_we       = 1'b1;
          res_status_d = STAT_OK;
          res_idx_d    = count_q[IDX_W-1:0];
          count_d      = count_q + 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_SEARCH: begin
        // Read, distance and compare run as a three-deep pipeline over the palette.
        rd_vld_d   = issue;
        rd_idx_d   = addr_q[IDX_W-1:0];
        if (issue) begin
          addr_d = addr_q + 1'b1;
        end
        dist_vld_d = rd_vld_q;
        dist_d     = dist_nx;
        dist_idx_d = rd_idx_q;
        if (dist_vld_q && (dist_idx_q == '0 || dist_q < res_dist_q)) begin
          res_dist_d = dist_q;
          res_idx_d  = dist_idx_q;
        end
        if (!issue && !rd_vld_q && !dist_vld_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_load | (out_valid_q & ~m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sum_q         <= '0;
      tally_q       <= '0;
      count_q       <= '0;
      region_side_q <= REGION_SIDE_RESET;
      rd_vld_q      <= 1'b0;
      dist_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      tally_q     <= tally_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      dist_vld_q  <= dist_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        region_side_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    region_q     <= region_d;
    avg_q        <= avg_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_dist_q   <= res_dist_d;
    addr_q       <= addr_d;
    rd_idx_q     <= rd_idx_d;
    dist_idx_q   <= dist_idx_d;
    dist_q       <= dist_d;
    if (out_load) begin
      out_kind_q   <= region_q;
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_dist_q   <= res_dist_q;
      out_avg_q    <= avg_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {2'b00, out_avg_q[2], out_avg_q[1], out_avg_q[0], out_dist_q,
                          OUT_IDX_W'(out_idx_q), out_status_q};

  bapm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Writes happen only in the store step and reads only in the walk, so they never overlap.
  bapm_palette_ram u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({avg_q[0], avg_q[1], avg_q[2]}),
    .re_i    (issue),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

### hw/rtl/bapm_palette_ram.sv
// Palette storage: one write port, one read port with registered read data.
// Depends on bapm_pkg.
module bapm_palette_ram (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [bapm_pkg::IDX_W-1:0]   waddr_i,
  input  logic [bapm_pkg::COLOR_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [bapm_pkg::IDX_W-1:0]   raddr_i,
  output logic [bapm_pkg::COLOR_W-1:0] rdata_o
);
  import bapm_pkg::*;

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/bapm_divider.sv
// Restoring divider for the three channel sums, one quotient bit per cycle.
// Depends on bapm_pkg; results saturate at the top of the channel range.
module bapm_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bapm_pkg::div_req_t  req_i,
  output bapm_pkg::div_rsp_t  rsp_o
);
  import bapm_pkg::*;

  localparam int REM_W = TALLY_W + 1;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [DIV_CNT_W-1:0]          cnt_q, cnt_d;
  logic [TALLY_W-1:0]            div_q, div_d;
  logic [NUM_CH-1:0][SUM_W-1:0]  dvd_q, dvd_d;
  logic [NUM_CH-1:0][SUM_W-1:0]  quo_q, quo_d;
  logic [NUM_CH-1:0][TALLY_W-1:0] rem_q, rem_d;

  logic [REM_W-1:0] trial [NUM_CH];
  logic             fits  [NUM_CH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem_q[c], dvd_q[c][SUM_W-1]};
      fits[c]  = trial[c] >= {1'b0, div_q};
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.divisor;
      dvd_d  = req_i.dividend;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem_d[c] = fits[c] ? TALLY_W'(trial[c] - {1'b0, div_q}) : TALLY_W'(trial[c]);
        quo_d[c] = {quo_q[c][SUM_W-2:0], fits[c]};
        dvd_d[c] = {dvd_q[c][SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    for (int c = 0; c < NUM_CH; c++) begin
      rsp_o.avg[c] = (|quo_q[c][SUM_W-1:CH_W]) ? {CH_W{1'b1}} : quo_q[c][CH_W-1:0];
    end
  end

endmodule

### hw/rtl/bapm_checker.sv
// Port-level checks of the palette matcher's result stream.
// Depends on bapm_pkg; bound to block_average_palette_match below.
module bapm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bapm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);
  import bapm_pkg::*;

  // A result that is not taken stays on the bus unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Tile results carry no distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[29:12] == '0)
    else $error("tile result with nonzero distance");

  // An empty palette is only reported for regions, with index and distance zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == STAT_EMPTY |->
      m_axis_tuser && m_axis_tdata[29:2] == '0)
    else $error("malformed empty-palette result");

  // A full palette is only reported for tiles, with index zero, and no status code 3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[55:54] == 2'b00
      && (m_axis_tdata[1:0] != STAT_FULL || (!m_axis_tuser && m_axis_tdata[11:2] == '0)))
    else $error("malformed result status");

endmodule

bind block_average_palette_match bapm_checker u_bapm_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for block_average_palette_match: directed table, random groups, fill test.
// Depends on bapm_pkg and the block's RTL; an internal predictor supplies the expected results.
module tb_top;
  import bapm_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic       KIND_TILE   = 1'b0;
  localparam logic       KIND_REGION = 1'b1;

  localparam int unsigned GAP_NONE   = 0;
  localparam int unsigned GAP_SPARSE = 1;
  localparam int unsigned GAP_DENSE  = 2;

  localparam int STUCK_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_PIXELS  = 60;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [9:0]  index;
    logic [17:0] distance;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } match_t;

  typedef struct packed {
    logic       do_cfg;
    logic [6:0] side;
    pixel_t     px;
    logic       typed;
    match_t     want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [SIDE_W-1:0]     cfg_data_i;

  // Predictor state: palette entries hold channel 0 red, 1 green, 2 blue.
  logic [2:0][7:0] pal_mem [PALETTE_DEPTH];
  int unsigned     pal_count;
  int unsigned     chan_sum [3];
  int unsigned     tally;
  logic [6:0]      side_reg;

  match_t      expected_matches[$];
  step_t       directed_steps[$];
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_taken = 0;
  int unsigned stuck_cycles = 0;
  bit          sender_gaps_on = 1'b1;
  int unsigned tx_run = 0, tx_mode = GAP_NONE;
  int unsigned rx_run = 0, rx_mode = GAP_NONE;
  match_t      seen, due;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  block_average_palette_match DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic pixel_t make_px(input logic [1:0] op, input logic [7:0] r,
                                     input logic [7:0] g, input logic [7:0] b,
                                     input logic last);
    pixel_t px;
    px.op    = op;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    px.last  = last;
    return px;
  endfunction

  function automatic match_t make_match(input logic kind, input logic [1:0] status,
                                        input logic [9:0] index, input logic [17:0] distance,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    match_t m;
    m.kind     = kind;
    m.status   = status;
    m.index    = index;
    m.distance = distance;
    m.red      = r;
    m.green    = g;
    m.blue     = b;
    return m;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: begin
        return 8'd0;
      end
      1: begin
        return 8'd255;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Idle cycles come in runs of a single style: none, occasional or heavy.
  function automatic int unsigned pick_wait(inout int unsigned run_left,
                                            inout int unsigned gap_mode);
    if (run_left == 0) begin
      gap_mode = $urandom_range(GAP_NONE, GAP_DENSE);
      run_left = $urandom_range(20, 60);
    end
    run_left--;
    if (gap_mode == GAP_NONE) return 0;
    if (gap_mode == GAP_SPARSE && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // Updates the palette and accumulator for one pixel; returns 1 when a result is due.
  function automatic bit predict_match(input pixel_t px, output match_t res);
    logic [2:0][7:0] avg;
    int unsigned     divisor, q, d, best, side_eff;
    int              dc;
    res  = '0;
    best = 0;
    if (px.op == OP_UNUSED) return 1'b0;
    if (px.op == OP_CLEAR) begin
      pal_count = 0;
      chan_sum  = '{0, 0, 0};
      tally     = 0;
      return 1'b0;
    end
    if (tally < MAX_TILE_PIXELS) begin
      chan_sum[0] += px.red;
      chan_sum[1] += px.green;
      chan_sum[2] += px.blue;
      tally++;
    end
    if (!px.last) return 1'b0;

    side_eff = (side_reg == 0) ? 1 : side_reg;
    divisor  = (px.op == OP_TILE) ? tally : side_eff * side_eff;
    for (int c = 0; c < 3; c++) begin
      q      = chan_sum[c] / divisor;
      avg[c] = (q > 255) ? 8'd255 : q[7:0];
    end
    res.kind  = px.op[0];
    res.red   = avg[0];
    res.green = avg[1];
    res.blue  = avg[2];

    if (px.op == OP_TILE) begin
      if (pal_count >= PALETTE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        pal_mem[pal_count] = avg;
        res.index          = pal_count[9:0];
        pal_count++;
      end
    end else if (pal_count == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      // Strict less-than keeps the earliest entry on a tie.
      for (int unsigned i = 0; i < pal_count; i++) begin
        d = 0;
        for (int c = 0; c < 3; c++) begin
          dc = int'(pal_mem[i][c]) - int'(avg[c]);
          d += dc * dc;
        end
        if (i == 0 || d < best) begin
          best      = d;
          res.index = i[9:0];
        end
      end
      res.distance = best[17:0];
    end
    chan_sum = '{0, 0, 0};
    tally    = 0;
    return 1'b1;
  endfunction

  task automatic add_step(input logic do_cfg, input logic [6:0] side, input pixel_t px,
                          input logic typed, input match_t want);
    step_t st;
    st             = {do_cfg, side, px, typed, want};
    directed_steps = {directed_steps, st};
  endtask

  // One input transaction; the expectation is queued once the pixel is taken.
  task automatic send_pixel(input pixel_t px, input logic typed, input match_t want);
    int unsigned gap;
    match_t      res;
    gap = sender_gaps_on ? pick_wait(tx_run, tx_mode) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.blue, px.green, px.red};
    s_axis_tuser  <= px.op;
    s_axis_tlast  <= px.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_match(px, res)) begin
      if (typed) res = want;
      expected_matches = {expected_matches, res};
    end
    if (px.op != OP_UNUSED) pixels_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(input logic [6:0] side);
    cfg_data_i  <= side;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    side_reg = side;
  endtask

  // Mostly complete tiles and regions, with clears, ignored items and mixed tags mixed in.
  task automatic random_group();
    int unsigned side_eff, area, len, pick;
    logic [1:0]  op;
    pixel_t      px;
    side_eff = (side_reg == 0) ? 1 : side_reg;
    area     = side_eff * side_eff;
    pick     = $urandom_range(0, 99);
    if (pick < 4) begin
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        op = $urandom_range(0, 1) ? OP_REGION : OP_TILE;
        send_pixel(make_px(op, rand_chan(), rand_chan(), rand_chan(), 1'b0), 1'b0, '0);
      end
      send_pixel(make_px(OP_CLEAR, rand_chan(), rand_chan(), rand_chan(),
                         1'($urandom_range(0, 1))), 1'b0, '0);
      return;
    end
    if (pick < 9) begin
      send_pixel(make_px(OP_UNUSED, rand_chan(), rand_chan(), rand_chan(),
                         1'($urandom_range(0, 1))), 1'b0, '0);
      return;
    end
    op = (pick < 52) ? OP_TILE : OP_REGION;
    if (op == OP_TILE) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    end else if (area > 30) begin
      len = $urandom_range(1, 30);
    end else if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, area + 3);
    end else begin
      len = area;
    end
    for (int i = 1; i <= len; i++) begin
      if ($urandom_range(0, 31) == 0) begin
        send_pixel(make_px(OP_UNUSED, rand_chan(), rand_chan(), rand_chan(), 1'b1), 1'b0, '0);
      end
      px = make_px(op, rand_chan(), rand_chan(), rand_chan(), 1'(i == len));
      if ($urandom_range(0, 15) == 0) px.op = (op == OP_TILE) ? OP_REGION : OP_TILE;
      send_pixel(px, 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind     = m_axis_tuser;
      seen.status   = m_axis_tdata[1:0];
      seen.index    = m_axis_tdata[11:2];
      seen.distance = m_axis_tdata[29:12];
      seen.red      = m_axis_tdata[37:30];
      seen.green    = m_axis_tdata[45:38];
      seen.blue     = m_axis_tdata[53:46];
      if (expected_matches.size() == 0) begin
        report_mismatch("unexpected result, entry_index", seen.index, 0);
      end else begin
        due = expected_matches.pop_front();
        if (seen.kind != due.kind) report_mismatch("kind", seen.kind, due.kind);
        if (seen.status != due.status) report_mismatch("status", seen.status, due.status);
        if (seen.index != due.index) report_mismatch("entry_index", seen.index, due.index);
        if (seen.distance != due.distance) begin
          report_mismatch("best_distance", seen.distance, due.distance);
        end
        if (seen.red != due.red) report_mismatch("avg_red", seen.red, due.red);
        if (seen.green != due.green) report_mismatch("avg_green", seen.green, due.green);
        if (seen.blue != due.blue) report_mismatch("avg_blue", seen.blue, due.blue);
      end
    end
  end

  // Result side: random stalls, plus two long hold-offs that back the block up to its input.
  initial begin : result_sink
    int unsigned hold;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = pick_wait(rx_run, rx_mode);
      if (results_taken == 100 || results_taken == 700) hold = 400;
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [6:0]  sides [9];
    int unsigned phase_start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    pal_count     = 0;
    chan_sum      = '{0, 0, 0};
    tally         = 0;
    side_reg      = REGION_SIDE_RESET;
    sides         = '{7'd3, 7'd2, 7'd1, 7'd5, 7'd64, 7'd0, 7'd127, 7'd4, 7'd10};

    // Region side starts at its reset value; the first region meets an empty palette.
    add_step(0, 0, make_px(OP_REGION, 255, 255, 255, 1), 1,
             make_match(KIND_REGION, STAT_EMPTY, 0, 0, 2, 2, 2));
    add_step(0, 0, make_px(OP_TILE, 0, 0, 0, 1), 1,
             make_match(KIND_TILE, STAT_OK, 0, 0, 0, 0, 0));
    add_step(0, 0, make_px(OP_TILE, 255, 255, 255, 1), 1,
             make_match(KIND_TILE, STAT_OK, 1, 0, 255, 255, 255));
    add_step(0, 0, make_px(OP_TILE, 255, 0, 170, 0), 0, '0);
    add_step(0, 0, make_px(OP_TILE, 254, 1, 85, 1), 0, '0);
    // Mixed tags share the accumulator; the tag of the last pixel decides the ending.
    add_step(0, 0, make_px(OP_REGION, 200, 100, 50, 0), 0, '0);
    add_step(0, 0, make_px(OP_UNUSED, 1, 2, 3, 1), 0, '0);
    add_step(0, 0, make_px(OP_TILE, 100, 200, 0, 1), 0, '0);
    add_step(0, 0, make_px(OP_TILE, 9, 9, 9, 0), 0, '0);
    add_step(0, 0, make_px(OP_REGION, 255, 0, 255, 1), 0, '0);
    // A clear drops the partial group as well as the palette.
    add_step(0, 0, make_px(OP_TILE, 77, 77, 77, 0), 0, '0);
    add_step(0, 0, make_px(OP_CLEAR, 255, 255, 255, 1), 0, '0);
    add_step(0, 0, make_px(OP_REGION, 0, 0, 0, 1), 1,
             make_match(KIND_REGION, STAT_EMPTY, 0, 0, 0, 0, 0));
    // Side zero divides like side one; equal distances go to the lower index.
    add_step(1, 0, make_px(OP_TILE, 200, 100, 7, 1), 1,
             make_match(KIND_TILE, STAT_OK, 0, 0, 200, 100, 7));
    add_step(0, 0, make_px(OP_REGION, 200, 100, 7, 1), 1,
             make_match(KIND_REGION, STAT_OK, 0, 0, 200, 100, 7));
    add_step(0, 0, make_px(OP_TILE, 200, 100, 7, 1), 1,
             make_match(KIND_TILE, STAT_OK, 1, 0, 200, 100, 7));
    add_step(0, 0, make_px(OP_REGION, 201, 98, 7, 1), 1,
             make_match(KIND_REGION, STAT_OK, 0, 5, 201, 98, 7));
    // More pixels than the region area saturate the averages.
    add_step(1, 1, make_px(OP_REGION, 255, 255, 255, 0), 0, '0);
    add_step(0, 0, make_px(OP_REGION, 255, 128, 1, 1), 0, '0);
    add_step(1, 64, make_px(OP_REGION, 255, 255, 255, 1), 0, '0);
    add_step(1, 127, make_px(OP_REGION, 255, 255, 255, 1), 0, '0);
    add_step(1, 1, make_px(OP_REGION, 0, 255, 0, 1), 0, '0);
    add_step(0, 0, make_px(OP_CLEAR, 0, 0, 0, 0), 0, '0);
    add_step(0, 0, make_px(OP_TILE, 0, 0, 0, 1), 1,
             make_match(KIND_TILE, STAT_OK, 0, 0, 0, 0, 0));
    add_step(0, 0, make_px(OP_REGION, 255, 255, 255, 1), 1,
             make_match(KIND_REGION, STAT_OK, 0, 195075, 255, 255, 255));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].do_cfg) begin
        settle();
        write_side(directed_steps[k].side);
      end
      send_pixel(directed_steps[k].px, directed_steps[k].typed, directed_steps[k].want);
    end

    foreach (sides[p]) begin
      settle();
      write_side(sides[p]);
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_PIXELS) random_group();
    end

    // Fill the palette, overflow it, then search it end to end.
    settle();
    write_side(1);
    send_pixel(make_px(OP_CLEAR, 0, 0, 0, 1), 1'b0, '0);
    for (int n = 0; n < PALETTE_DEPTH + 2; n++) begin
      send_pixel(make_px(OP_TILE, rand_chan(), rand_chan(), rand_chan(), 1'b1), 1'b0, '0);
    end
    send_pixel(make_px(OP_TILE, rand_chan(), rand_chan(), rand_chan(), 1'b0), 1'b0, '0);
    send_pixel(make_px(OP_TILE, rand_chan(), rand_chan(), rand_chan(), 1'b1), 1'b0, '0);
    for (int n = 0; n < 3; n++) begin
      send_pixel(make_px(OP_REGION, rand_chan(), rand_chan(), rand_chan(), 1'b1), 1'b0, '0);
    end

    settle();
    if (mismatch_count == 0 && expected_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
